/* hdl/htf_pkg.sv */
// package for the histogram trough finder
// holds shared constants, the controller state type and the command/status structs
// no dependencies
`timescale 1ns / 1ps

package htf_pkg;

  // default parameter values
  localparam int WINDOW_DEF     = 5;
  localparam int MAX_FREQ_DEF   = 1024;
  localparam int COUNT_BITS_DEF = 48;

  // fixed port widths
  localparam int BIN_COUNT_W   = 48;
  localparam int TROUGH_FREQ_W = 10;
  localparam int AVERAGE_W     = 48;

  // quotient digits resolved per divider cycle
  localparam int DIV_DIGITS = 8;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ROUTE,
    S_DIV,
    S_BEST,
    S_MUL,
    S_CHECK,
    S_EMIT_EARLY,
    S_FINISH,
    S_EMIT_LAST
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic take;          // latch the input word
    logic seed;          // first bin seeds the minimum
    logic window;        // push bin into the rolling window, start divide
    logic div_step;      // one divider step
    logic best_update;   // compare average against minimum
    logic mul;           // register the rise threshold
    logic emit;          // load the output register
    logic emit_early;    // stopped_early flag for the emitted word
    logic set_done;      // scan stopped, swallow remaining bins
    logic clear;         // return scan state to reset values
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic active;        // bin is inside the scan
    logic first;         // bin is frequency one
    logic div_done;      // current divider cycle is the last one
    logic rise;          // window sum exceeds threshold
    logic last;          // latched last_bin mark
    logic done;          // scan already stopped early
    logic out_free;      // output register can take a word
  } status_t;

endpackage

/* hdl/htf_ctrl.sv */
// controller state machine of the histogram trough finder
// sequences window update, divide, minimum update and rise check; uses htf_pkg
`timescale 1ns / 1ps

module htf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output htf_pkg::cmd_t    cmd,
  input  htf_pkg::status_t status
);
  import htf_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // only take a word when the sequencer is free
  assign in_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_ROUTE;
        end
      end
      S_ROUTE: begin
        if (!status.active) begin
          state_next = S_FINISH;
        end else if (status.first) begin
          cmd.seed   = 1'b1;
          state_next = S_FINISH;
        end else begin
          cmd.window = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = S_BEST;
        end
      end
      S_BEST: begin
        cmd.best_update = 1'b1;
        state_next      = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = status.rise ? S_EMIT_EARLY : S_FINISH;
      end
      S_EMIT_EARLY: begin
        if (status.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_early = 1'b1;
          cmd.set_done   = 1'b1;
          state_next     = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!status.last) begin
          state_next = S_IDLE;
        end else if (status.done) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_EMIT_LAST;
        end
      end
      S_EMIT_LAST: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/htf_dpath.sv */
// datapath of the histogram trough finder
// rolling window, digit-serial divider, minimum tracking and output register; uses htf_pkg
`timescale 1ns / 1ps

module htf_dpath #(
  parameter int WINDOW     = htf_pkg::WINDOW_DEF,
  parameter int MAX_FREQ   = htf_pkg::MAX_FREQ_DEF,
  parameter int COUNT_BITS = htf_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  htf_pkg::cmd_t                     cmd,
  output htf_pkg::status_t                  status,
  input  logic [htf_pkg::BIN_COUNT_W-1:0]   bin_count,
  input  logic                              last_bin,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [htf_pkg::TROUGH_FREQ_W-1:0] trough_freq,
  output logic [htf_pkg::AVERAGE_W-1:0]     trough_average,
  output logic                              stopped_early
);
  import htf_pkg::*;

  localparam int CW     = COUNT_BITS;
  localparam int SW     = CW + $clog2(WINDOW);
  localparam int FLW    = $clog2(WINDOW + 1);
  localparam int SLW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FW     = $clog2(MAX_FREQ);
  localparam int NSTEPS = (SW + DIV_DIGITS - 1) / DIV_DIGITS;
  localparam int QW     = NSTEPS * DIV_DIGITS;
  localparam int CNTW   = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
  localparam int MW     = CW + $clog2(2 * WINDOW);
  localparam int PW     = (MW > 64) ? 64 : MW;

  // input word
  logic [CW-1:0] v_reg;
  logic          last_reg;

  // scan state
  logic [CW-1:0]  win [WINDOW];
  logic [SW-1:0]  sum;
  logic [FLW-1:0] fill;
  logic [SLW-1:0] slot;
  logic [CW-1:0]  best;
  logic [FW-1:0]  best_freq;
  logic [FW-1:0]  pos;
  logic           done;

  // divider and threshold
  logic [QW-1:0]   dvd, dvd_next;
  logic [FLW-1:0]  rem, rem_next;
  logic [CNTW-1:0] cnt;
  logic [PW-1:0]   thr;

  logic [FW:0]    pos_inc;
  logic           full;
  logic [SW-1:0]  sum_new;
  logic [FLW-1:0] fill_new;
  logic [CW-1:0]  ave;

  // window arithmetic
  assign pos_inc  = {1'b0, pos} + (FW + 1)'(1);
  assign full     = (fill == FLW'(WINDOW));
  assign sum_new  = full ? (sum + SW'(v_reg) - SW'(win[slot])) : (sum + SW'(v_reg));
  assign fill_new = full ? fill : (fill + FLW'(1));
  assign ave      = dvd[CW-1:0];

  // status to controller
  always_comb begin
    status          = '0;
    status.active   = !done && (pos_inc < (FW + 1)'(MAX_FREQ));
    status.first    = (pos == '0);
    status.div_done = (cnt == CNTW'(NSTEPS - 1));
    status.rise     = (thr < PW'(sum));
    status.last     = last_reg;
    status.done     = done;
    status.out_free = !out_valid || !out_stall;
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      v_reg    <= CW'(bin_count);
      last_reg <= last_bin;
    end
  end

  // window values, only read once written in the current histogram
  always_ff @(posedge clk) begin
    if (cmd.window) begin
      win[slot] <= v_reg;
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      sum       <= '0;
      fill      <= '0;
      slot      <= '0;
      best      <= '0;
      best_freq <= FW'(1);
      pos       <= '0;
      done      <= 1'b0;
    end else begin
      if (cmd.seed) begin
        best      <= v_reg;
        best_freq <= FW'(1);
        pos       <= pos_inc[FW-1:0];
      end
      if (cmd.window) begin
        pos  <= pos_inc[FW-1:0];
        sum  <= sum_new;
        fill <= fill_new;
        slot <= (slot == SLW'(WINDOW - 1)) ? '0 : slot + SLW'(1);
      end
      if (cmd.best_update && (ave < best)) begin
        best      <= ave;
        best_freq <= pos - FW'(fill >> 1);
      end
      if (cmd.set_done) begin
        done <= 1'b1;
      end
    end
  end

  // long division by the fill count, remainder stays below the divisor
  always_comb begin
    logic [FLW:0]  r2;
    logic          q;
    rem_next = rem;
    dvd_next = dvd;
    for (int i = 0; i < DIV_DIGITS; i++) begin
      r2       = {rem_next, dvd_next[QW-1]};
      q        = (r2 >= {1'b0, fill});
      r2       = q ? (r2 - {1'b0, fill}) : r2;
      rem_next = r2[FLW-1:0];
      dvd_next = {dvd_next[QW-2:0], q};
    end
  end

  // divider registers and rise threshold
  always_ff @(posedge clk) begin
    if (cmd.window) begin
      dvd <= QW'(sum_new);
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      dvd <= dvd_next;
      rem <= rem_next;
      cnt <= cnt + CNTW'(1);
    end
    if (cmd.mul) begin
      thr <= PW'(MW'(best) * MW'(2 * WINDOW));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      trough_freq    <= TROUGH_FREQ_W'(best_freq);
      trough_average <= AVERAGE_W'(best);
      stopped_early  <= cmd.emit_early;
    end
  end

endmodule

/* hdl/histogram_trough_finder.sv */
// top level of the histogram trough finder
// joins htf_ctrl and htf_dpath; uses htf_pkg
`timescale 1ns / 1ps

// Usage: histogram bin counts enter on the input channel (bin_count, last_bin,
// in_valid, in_stall), one word per frequency starting at frequency 1. The
// result word (trough_freq, trough_average, stopped_early) leaves on the output
// channel (out_valid, out_stall); at most one result per histogram.
// A word is moved on a rising edge where valid is high and stall is low.
// Sequencing: one input word at a time. A bin that is ignored, or the first bin,
// passes through the route and finish states; a window bin also passes through
// the divide, minimum, threshold and rise check states, the divide stepping the
// digit-serial divider, which resolves 8 quotient digits per cycle. A result adds
// an emit state and is visible on the output in the cycle after it.
// Early stop gives the result right away; the bins after it up to the last are
// swallowed. Otherwise the result follows the bin marked last.
// The output register holds a result while out_stall is high; the block keeps
// taking bins until it needs to write a further result.
// Reset (rst, synchronous) clears the scan state and the output valid; after
// the last bin the scan state returns to reset for the next histogram.

module histogram_trough_finder #(
  parameter int WINDOW     = htf_pkg::WINDOW_DEF,
  parameter int MAX_FREQ   = htf_pkg::MAX_FREQ_DEF,
  parameter int COUNT_BITS = htf_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [htf_pkg::BIN_COUNT_W-1:0]   bin_count,
  input  logic                              last_bin,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [htf_pkg::TROUGH_FREQ_W-1:0] trough_freq,
  output logic [htf_pkg::AVERAGE_W-1:0]     trough_average,
  output logic                              stopped_early
);
  import htf_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  htf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  // window, divider and result datapath
  htf_dpath #(
    .WINDOW     (WINDOW),
    .MAX_FREQ   (MAX_FREQ),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .bin_count      (bin_count),
    .last_bin       (last_bin),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .trough_freq    (trough_freq),
    .trough_average (trough_average),
    .stopped_early  (stopped_early)
  );

endmodule

/* tb/tb_top.sv */
// self-checking testbench for histogram_trough_finder: drives histograms of bin words,
// predicts the trough word of each one and checks it; uses htf_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_top;
  import htf_pkg::*;

  localparam int HIST_WIN = WINDOW_DEF;
  localparam int FREQ_CAP = MAX_FREQ_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [BIN_COUNT_W-1:0] MAXC = '1;

  typedef logic [BIN_COUNT_W-1:0] count_t;

  typedef struct packed {
    logic [TROUGH_FREQ_W-1:0] freq;
    logic [AVERAGE_W-1:0]     avg;
    logic                     early;
  } trough_t;

  typedef struct packed {
    count_t  cnt;
    logic    lst;
    logic    typed;
    trough_t want;
  } bin_row_t;

  // hand-written histograms: single bins, immediate rise, rise on the last bin,
  // all-ones counts, a falling run that wraps the window, alternating bits
  localparam bin_row_t DIRECTED [22] = '{
    '{MAXC, 1'b1, 1'b1, '{10'd1, MAXC, 1'b0}},
    '{48'd0, 1'b1, 1'b1, '{10'd1, 48'd0, 1'b0}},
    '{48'd0, 1'b0, 1'b0, '0},
    '{48'd1, 1'b0, 1'b1, '{10'd1, 48'd0, 1'b1}},
    '{48'd5, 1'b0, 1'b0, '0},
    '{48'd7, 1'b1, 1'b0, '0},
    '{48'd0, 1'b0, 1'b0, '0},
    '{48'd3, 1'b1, 1'b1, '{10'd1, 48'd0, 1'b1}},
    '{MAXC, 1'b0, 1'b0, '0},
    '{MAXC, 1'b0, 1'b0, '0},
    '{MAXC, 1'b0, 1'b0, '0},
    '{MAXC, 1'b1, 1'b1, '{10'd1, MAXC, 1'b0}},
    '{48'd1000, 1'b0, 1'b0, '0},
    '{48'd800, 1'b0, 1'b0, '0},
    '{48'd600, 1'b0, 1'b0, '0},
    '{48'd400, 1'b0, 1'b0, '0},
    '{48'd200, 1'b0, 1'b0, '0},
    '{48'd100, 1'b0, 1'b0, '0},
    '{48'd90, 1'b0, 1'b0, '0},
    '{48'd3000, 1'b1, 1'b0, '0},
    '{48'hAAAA_AAAA_AAAA, 1'b0, 1'b0, '0},
    '{48'h5555_5555_5555, 1'b1, 1'b0, '0}
  };

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  count_t                   bin_count;
  logic                     last_bin;
  logic                     out_valid;
  logic                     out_stall;
  logic [TROUGH_FREQ_W-1:0] trough_freq;
  logic [AVERAGE_W-1:0]     trough_average;
  logic                     stopped_early;

  histogram_trough_finder DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .bin_count      (bin_count),
    .last_bin       (last_bin),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .trough_freq    (trough_freq),
    .trough_average (trough_average),
    .stopped_early  (stopped_early)
  );

  // trough words still to come, oldest first
  trough_t pending_troughs [$];
  trough_t seen_want;
  int      errors = 0;
  bit      idle_on = 1'b0;

  // predicted scan state
  count_t                   win_vals [HIST_WIN];
  logic [63:0]              win_sum;
  int unsigned              win_fill;
  count_t                   min_avg;
  logic [TROUGH_FREQ_W-1:0] min_freq;
  int unsigned              bins_seen;
  bit                       swallowing;

  function automatic void clear_scan();
    foreach (win_vals[i]) win_vals[i] = '0;
    win_sum    = '0;
    win_fill   = 0;
    min_avg    = '0;
    min_freq   = 1;
    bins_seen  = 0;
    swallowing = 1'b0;
  endfunction

  // append a predicted trough word at the tail
  function automatic void queue_trough(input trough_t t);
    pending_troughs.insert(pending_troughs.size(), t);
  endfunction

  // advance the scan by one bin; returns 1 when the bin yields a trough word
  function automatic bit scan_bin(input count_t c, input logic lst, output trough_t r);
    int unsigned freq;
    int unsigned slot;
    logic [63:0] avg;
    bit          hit;
    hit = 1'b0;
    r = '0;
    if (!swallowing && bins_seen + 1 < FREQ_CAP) begin
      freq = bins_seen + 1;
      bins_seen = freq;
      if (freq == 1) begin
        min_avg = c;
        min_freq = 1;
      end else begin
        slot = (freq - 2) % HIST_WIN;
        if (win_fill >= HIST_WIN) begin
          win_sum = win_sum + 64'(c) - 64'(win_vals[slot]);
        end else begin
          win_sum = win_sum + 64'(c);
          win_fill++;
        end
        win_vals[slot] = c;
        avg = win_sum / 64'(win_fill);
        if (avg < 64'(min_avg)) begin
          min_avg = avg[BIN_COUNT_W-1:0];
          min_freq = TROUGH_FREQ_W'(freq - win_fill / 2);
        end
        // rise past twice the minimum ends the scan
        if (64'(min_avg) * 64'(2 * HIST_WIN) < win_sum) begin
          r = '{min_freq, min_avg, 1'b1};
          hit = 1'b1;
          swallowing = 1'b1;
        end
      end
    end
    if (lst) begin
      if (!hit && !swallowing) begin
        r = '{min_freq, min_avg, 1'b0};
        hit = 1'b1;
      end
      clear_scan();
    end
    return hit;
  endfunction

  // mostly short gaps, a few long ones, none while idling is off
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic count_t rand_count();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    if ($urandom_range(0, 3) == 0) return raw[BIN_COUNT_W-1:0];
    return raw[BIN_COUNT_W-1:0] >> $urandom_range(0, 47);
  endfunction

  function automatic count_t sat_count(input logic [63:0] v);
    return (v > 64'(MAXC)) ? MAXC : v[BIN_COUNT_W-1:0];
  endfunction

  // send one bin word and record what it should produce
  task automatic send_bin(input count_t cnt, input logic lst, input bit typed,
                          input trough_t want);
    trough_t got;
    bit      hit;
    int      gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    bin_count <= cnt;
    last_bin  <= lst;
    do @(posedge clk); while (in_stall);
    hit = scan_bin(cnt, lst, got);
    if (typed) begin
      queue_trough(want);
    end else if (hit) begin
      queue_trough(got);
    end
  endtask

  // hold the sender until every trough word has arrived
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_troughs.size() != 0) @(posedge clk);
  endtask

  // one histogram: 0 valley with a rise, 1 noise, 2 flat within a quarter
  task automatic send_histogram(input int len, input int shape);
    count_t      base;
    count_t      w;
    logic [63:0] v;
    logic [63:0] raw;
    base = rand_count();
    v = 64'(base);
    for (int i = 0; i < len; i++) begin
      raw = {$urandom(), $urandom()};
      case (shape)
        0: begin
          if (i < len / 2) v = v - v / 64'($urandom_range(2, 6));
          else v = 64'(sat_count(v + v / 64'($urandom_range(1, 3)) + 64'($urandom_range(0, 3))));
          w = ($urandom_range(0, 15) == 0) ? '0 : v[BIN_COUNT_W-1:0];
        end
        1: begin
          w = rand_count();
        end
        default: begin
          w = sat_count(64'(base) + raw % (64'(base) / 4 + 1));
        end
      endcase
      send_bin(w, i == len - 1, 1'b0, '0);
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  initial begin
    for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // receiver stall pattern
  initial begin
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!idle_on) begin
        out_stall <= 1'b0;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            out_stall <= 1'b0;
            hold = $urandom_range(0, 4);
          end
          9: begin
            out_stall <= 1'b1;
            hold = $urandom_range(10, 40);
          end
          default: begin
            out_stall <= 1'b1;
            hold = $urandom_range(0, 2);
          end
        endcase
      end
    end
  end

  // compare each accepted trough word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_troughs.size() == 0) begin
        $display("%0t: unexpected word freq %0d avg %0d early %0b", $realtime,
                 trough_freq, trough_average, stopped_early);
        errors++;
      end else begin
        seen_want = pending_troughs.pop_front();
        if (trough_freq !== seen_want.freq) begin
          $display("%0t: trough_freq expected %0d actual %0d", $realtime,
                   seen_want.freq, trough_freq);
          errors++;
        end
        if (trough_average !== seen_want.avg) begin
          $display("%0t: trough_average expected %0d actual %0d", $realtime,
                   seen_want.avg, trough_average);
          errors++;
        end
        if (stopped_early !== seen_want.early) begin
          $display("%0t: stopped_early expected %0b actual %0b", $realtime,
                   seen_want.early, stopped_early);
          errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int bins_sent;
    int hist_cnt;
    int len;
    int r;
    int shape;
    bins_sent = 0;
    hist_cnt  = 0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    bin_count = '0;
    last_bin  = 1'b0;
    clear_scan();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed histograms, no idling
    foreach (DIRECTED[i]) begin
      send_bin(DIRECTED[i].cnt, DIRECTED[i].lst, DIRECTED[i].typed, DIRECTED[i].want);
    end
    drain();

    // random histograms, mostly valleys that rise
    while (bins_sent < 700) begin
      if (hist_cnt % 12 == 0) idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      shape = (r < 60) ? 0 : (r < 85) ? 1 : 2;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      send_histogram(len, shape);
      bins_sent += len;
      hist_cnt++;
      if ($urandom_range(0, 14) == 0) drain();
    end

    // wait out the last word and let the block settle
    drain();
    repeat (60) @(posedge clk);
    if (pending_troughs.size() != 0) begin
      $display("%0t: %0d trough words never arrived", $realtime, pending_troughs.size());
      errors++;
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
